@@ rtl/sds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared types, codes and widths for the scheduler cells, the result stage
// and the top level.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int CYL_W  = 16;
    localparam int MOVE_W = 18;
    localparam int CFG_W  = 2;

    localparam logic [MOVE_W-1:0] MOVE_MAX = 18'h3FFFF;

    // configuration register indexes
    typedef enum logic [CFG_W-1:0] {
        CFG_LOWER = 2'd0,
        CFG_UPPER = 2'd1,
        CFG_START = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_LOWER   = 2'd2,
        KIND_UPPER   = 2'd3
    } t_stop_kind;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_ROT,
        ST_DOWN,
        ST_LOWER,
        ST_UP,
        ST_UPPER
    } t_state;

    // operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_CLEAR,
        OP_ROTATE,
        OP_SHIFT_UP
    } t_cell_op;

    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             last_request;
    } t_in_item;

    typedef struct packed {
        logic [CYL_W-1:0]  stop_cylinder;
        t_stop_kind        stop_kind;
        logic [MOVE_W-1:0] total_movement;
        logic              overflow;
        logic              last_stop;
    } t_out_item;

    // what one cell hands to its neighbors
    typedef struct packed {
        logic [CYL_W-1:0] val;
        logic             tag;
        logic             gt;
    } t_link;

    // stop request from the sequencer to the result stage
    typedef struct packed {
        logic             push;
        logic             first;
        logic [CYL_W-1:0] cyl;
        t_stop_kind       kind;
        logic             overflow;
        logic             last;
    } t_stop_req;

endpackage

@@ rtl/scan_disk_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler unit
// Collects a batch of request cylinders in a sorted cell chain and emits the
// elevator service order with running head movement.
// ----------------------------------------------------------------------------
// Loading takes one request per cycle: every transfer inserts into a chain of
// MAX_REQUESTS cells, and requests beyond capacity are dropped with the
// overflow flag raised for that batch. The transfer marked last closes the
// batch and the input stalls while the schedule is emitted. Emission runs
// from the chain's ends: first the start stop, then the chain rotates down
// once per request at or below the head (no result), moving those requests
// to the top where they are popped in descending order, then the lower end,
// then the remaining requests are popped ascending from the bottom, then the
// upper end. One output register sits between the sequencer and the result
// port.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_unit import sds_pkg::*; #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_index,
    input  logic [CYL_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    localparam int               CW   = $clog2(MAX_REQUESTS + 1);
    localparam logic [CW-1:0]    FULL = CW'(MAX_REQUESTS);

    // configuration registers
    logic [CYL_W-1:0] r_lower;
    logic [CYL_W-1:0] r_upper;
    logic [CYL_W-1:0] r_start;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_dropped;
    logic          n_dropped;

    t_cell_op  w_op;
    t_stop_req w_req;
    logic      w_take;
    t_link     w_link [MAX_REQUESTS];
    t_link     w_wrap;
    t_link     w_zero;

    // ------------------------------------------------------------------
    // Configuration writes; indexes past the list are ignored
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '1;
            r_start <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                CFG_START: r_start <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: the bottom cell wraps to the top cell on rotation and
    // the top cell tags what it receives, so the lower sweep lands at the top in order
    // ------------------------------------------------------------------
    assign w_wrap = '{val: w_link[0].val, tag: 1'b1, gt: 1'b0};
    assign w_zero = '0;

    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        t_link w_below;
        t_link w_above;
        logic  w_occ;

        if (g == 0) begin : g_bottom
            assign w_below = w_zero;
        end else begin : g_mid_lo
            assign w_below = w_link[g-1];
        end

        if (g == MAX_REQUESTS - 1) begin : g_top
            assign w_above = w_wrap;
        end else begin : g_mid_hi
            assign w_above = w_link[g+1];
        end

        assign w_occ = r_count > CW'(g);

        sds_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_key   (i_in_data.request_cylinder),
            .i_occ   (w_occ),
            .i_below (w_below),
            .i_above (w_above),
            .o_link  (w_link[g])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_dropped      = r_dropped;
        w_op           = OP_HOLD;
        w_req          = '0;
        w_req.overflow = r_dropped;
        o_in_stall     = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    // insert while there is room, drop and flag otherwise
                    if (r_count < FULL) begin
                        w_op    = OP_INSERT;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_data.last_request) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                // clear old tags while the head position goes out
                w_op        = OP_CLEAR;
                w_req.push  = 1'b1;
                w_req.first = 1'b1;
                w_req.cyl   = r_start;
                w_req.kind  = KIND_START;
                if (w_take) begin
                    n_state = ST_ROT;
                end
            end
            ST_ROT: begin
                // move every request at or below the head to the top
                if ((r_count != '0) && (w_link[0].val <= r_start)) begin
                    w_op    = OP_ROTATE;
                    n_count = r_count - CW'(1);
                end else begin
                    n_state = ST_DOWN;
                end
            end
            ST_DOWN: begin
                // pop the tagged region from the top, descending
                if (w_link[MAX_REQUESTS-1].tag) begin
                    w_req.push = 1'b1;
                    w_req.cyl  = w_link[MAX_REQUESTS-1].val;
                    w_req.kind = KIND_REQUEST;
                    if (w_take) begin
                        w_op = OP_SHIFT_UP;
                    end
                end else begin
                    n_state = ST_LOWER;
                end
            end
            ST_LOWER: begin
                w_req.push = 1'b1;
                w_req.cyl  = r_lower;
                w_req.kind = KIND_LOWER;
                if (w_take) begin
                    n_state = ST_UP;
                end
            end
            ST_UP: begin
                // pop the rest from the bottom, ascending
                if (r_count != '0) begin
                    w_req.push = 1'b1;
                    w_req.cyl  = w_link[0].val;
                    w_req.kind = KIND_REQUEST;
                    if (w_take) begin
                        w_op    = OP_ROTATE;
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    n_state = ST_UPPER;
                end
            end
            ST_UPPER: begin
                w_req.push = 1'b1;
                w_req.cyl  = r_upper;
                w_req.kind = KIND_UPPER;
                w_req.last = 1'b1;
                if (w_take) begin
                    n_state   = ST_LOAD;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------
    sds_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_take  (w_take),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("request count beyond chain capacity");

    a_drop_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && r_dropped) |-> (r_count == FULL))
        else $error("request dropped while the chain had room");

    a_start_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.stop_kind == KIND_START)
            |-> (o_out_data.total_movement == '0))
        else $error("start stop carries nonzero movement");

    a_last_upper : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_stop) |-> (o_out_data.stop_kind == KIND_UPPER))
        else $error("final stop is not the upper end");

endmodule

@@ rtl/sds_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler cell
// One slot of the sorted request chain: holds a cylinder and a sweep tag,
// inserts in order and shifts or rotates with its neighbors.
// ----------------------------------------------------------------------------
module sds_cell import sds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_op         i_op,
    input  logic [CYL_W-1:0] i_key,
    input  logic             i_occ,
    input  t_link            i_below,
    input  t_link            i_above,
    output t_link            o_link
);

    logic [CYL_W-1:0] r_val;
    logic [CYL_W-1:0] n_val;
    logic             r_tag;
    logic             n_tag;

    always_comb begin
        n_val = r_val;
        n_tag = r_tag;
        case (i_op)
            OP_INSERT: begin
                // take the lower neighbor when it moves up, else claim the key if empty or larger
                if (i_below.gt) begin
                    n_val = i_below.val;
                end else if (!i_occ || (r_val > i_key)) begin
                    n_val = i_key;
                end
            end
            OP_CLEAR: begin
                n_tag = 1'b0;
            end
            OP_ROTATE: begin
                n_val = i_above.val;
                n_tag = i_above.tag;
            end
            OP_SHIFT_UP: begin
                if (r_tag) begin
                    n_val = i_below.val;
                    n_tag = i_below.tag;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= 1'b0;
        end else begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.val = r_val;
    assign o_link.tag = r_tag;
    assign o_link.gt  = i_occ && (r_val > i_key);

endmodule

@@ rtl/sds_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler result stage
// Accumulates saturating head movement and holds one result for transfer.
// ----------------------------------------------------------------------------
module sds_out import sds_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stop_req i_req,
    output logic      o_take,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_item o_data
);

    logic              r_valid;
    t_out_item         r_data;
    logic [CYL_W-1:0]  r_head;
    logic [MOVE_W-1:0] r_total;

    logic [CYL_W-1:0]  w_base_head;
    logic [MOVE_W-1:0] w_base_total;
    logic [CYL_W-1:0]  w_diff;
    logic [MOVE_W:0]   w_sum;
    logic [MOVE_W-1:0] n_total;

    assign o_take = !r_valid || !i_stall;

    always_comb begin
        w_base_head  = i_req.first ? i_req.cyl : r_head;
        w_base_total = i_req.first ? '0 : r_total;
        if (i_req.cyl >= w_base_head) begin
            w_diff = i_req.cyl - w_base_head;
        end else begin
            w_diff = w_base_head - i_req.cyl;
        end
        w_sum = {1'b0, w_base_total} + {{(MOVE_W + 1 - CYL_W){1'b0}}, w_diff};
        // saturate at the top of the movement range
        if (w_sum > {1'b0, MOVE_MAX}) begin
            n_total = MOVE_MAX;
        end else begin
            n_total = w_sum[MOVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_req.push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_req.push) begin
            r_head                <= i_req.cyl;
            r_total               <= n_total;
            r_data.stop_cylinder  <= i_req.cyl;
            r_data.stop_kind      <= i_req.kind;
            r_data.total_movement <= n_total;
            r_data.overflow       <= i_req.overflow;
            r_data.last_stop      <= i_req.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
